// ===== rtl/pmg_pkg.sv =====
// shared types and constants for the point mass gravity force block
package pmg_pkg;

  // fixed datapath widths, sized for the widest fraction setting
  localparam int DW    = 33;   // coordinate offset
  localparam int AW    = 49;   // strength, mass times multiplier
  localparam int SW    = 66;   // squared distance
  localparam int RW    = 35;   // square root
  localparam int PW    = 120;  // shift-add product and dividend
  localparam int QW    = 33;   // quotient bits kept
  localparam int DDW   = PW + QW - 1;
  localparam int MUL_FRAC = 16;
  localparam int CNTW  = 6;

  localparam logic [2:0] CFG_CENTER_X   = 3'd0;
  localparam logic [2:0] CFG_CENTER_Y   = 3'd1;
  localparam logic [2:0] CFG_MASS       = 3'd2;
  localparam logic [2:0] CFG_MULTIPLIER = 3'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_MUL_XX, S_MUL_YY, S_SQRT, S_MUL_LR, S_MUL_AM,
    S_MUL_PX, S_DIV_X, S_MUL_PY, S_DIV_Y, S_FINISH
  } state_t;

  typedef enum logic [3:0] {
    OP_MUL_XX, OP_MUL_YY, OP_SQRT, OP_MUL_LR, OP_MUL_AM,
    OP_MUL_PX, OP_DIV_X, OP_MUL_PY, OP_DIV_Y
  } op_t;

  typedef struct packed {
    logic load;
    logic start;
    op_t  op;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic skip;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/point_mass_gravity_force_top.sv =====
// top level of the point mass gravity force block
//
//  channel  dir  handshake          payload
//  in_      in   tvalid / tready    tdata body_x, body_y, body_mass; tuser eligible, frame_start
//  out_     out  tvalid / tready    tdata force_x, force_y, reaction_x, reaction_y; tuser saturated
//  cfg_     in   we                 index, wdata
//
// a computed body runs six 35-step shift-add multiplies, a 35-step
// square root and two 33-step divisions on one shared counter, each launched on entry to its state
// a skipped body (ineligible, weak attractor or coincident) goes from the check state straight to finish
// one body at a time; the next transfer is taken once the result sits in the output register
// a stalled output holds the finished result and blocks only the final step of the next body
// synchronous active-low reset clears totals and handshake state and sets config to its defaults
module point_mass_gravity_force_top import pmg_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [95:0]  in_tdata,   // body_x, body_y, body_mass
  input  logic [1:0]   in_tuser,   // eligible, frame_start
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // force_x, force_y, reaction_x, reaction_y
  output logic         out_tuser   // saturated
);

  cmd_t    cmd;
  status_t st;

  pmg_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .st(st), .cmd(cmd)
  );

  pmg_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .cmd(cmd), .st(st)
  );

endmodule

// ===== rtl/pmg_ctrl.sv =====
// sequencer that steps one body through the shared arithmetic units
module pmg_ctrl import pmg_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  input  status_t st,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;
  logic   launched_r, launched_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      launched_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      launched_r <= launched_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd.load   = 1'b0;
    cmd.start  = 1'b0;
    cmd.op     = OP_MUL_XX;
    cmd.finish = 1'b0;
    in_tready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        // no transfer is taken while reset is held
        in_tready = rst_n;
        if (in_tvalid && rst_n) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK:  state_nxt = st.skip ? S_FINISH : S_MUL_XX;
      S_MUL_XX: begin
        cmd.op = OP_MUL_XX;
        if (st.done) state_nxt = S_MUL_YY;
      end
      S_MUL_YY: begin
        cmd.op = OP_MUL_YY;
        if (st.done) state_nxt = S_SQRT;
      end
      S_SQRT: begin
        cmd.op = OP_SQRT;
        if (st.done) state_nxt = S_MUL_LR;
      end
      S_MUL_LR: begin
        cmd.op = OP_MUL_LR;
        if (st.done) state_nxt = S_MUL_AM;
      end
      S_MUL_AM: begin
        cmd.op = OP_MUL_AM;
        if (st.done) state_nxt = S_MUL_PX;
      end
      S_MUL_PX: begin
        cmd.op = OP_MUL_PX;
        if (st.done) state_nxt = S_DIV_X;
      end
      S_DIV_X: begin
        cmd.op = OP_DIV_X;
        if (st.done) state_nxt = S_MUL_PY;
      end
      S_MUL_PY: begin
        cmd.op = OP_MUL_PY;
        if (st.done) state_nxt = S_DIV_Y;
      end
      S_DIV_Y: begin
        cmd.op = OP_DIV_Y;
        if (st.done) state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (st.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    // every compute phase launches its unit once on entry
    if (state_r != S_IDLE && state_r != S_CHECK && state_r != S_FINISH && !launched_r)
      cmd.start = 1'b1;
    launched_nxt = launched_r;
    if (cmd.start) launched_nxt = 1'b1;
    else if (st.done) launched_nxt = 1'b0;
  end

`ifndef SYNTHESIS
  a_done_launched: assert property (@(posedge clk) disable iff (!rst_n)
    st.done |-> launched_r) else $error("unit done without launch");
  a_load_check: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == S_CHECK) else $error("load not followed by check");
  a_start_once: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> !cmd.start) else $error("unit launched twice");
  a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> state_r == S_IDLE) else $error("finish did not return idle");
`endif

endmodule

// ===== rtl/pmg_datapath.sv =====
// config registers, shift-add multiplier, digit square root, divider and output register
module pmg_datapath import pmg_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [31:0]   cfg_wdata,
  input  logic [95:0]   in_tdata,
  input  logic [1:0]    in_tuser,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [127:0]  out_tdata,
  output logic          out_tuser,
  input  cmd_t          cmd,
  output status_t       st
);

  localparam logic [AW-17:0] EPS = (AW-16)'((64'd1 << FRAC_BITS) / 64'd10000);
  localparam logic [SW-1:0]  ONE = SW'(64'd1 << FRAC_BITS);

  logic [31:0] cx_r, cy_r, mass_r;
  logic [16:0] mult_r;
  logic signed [31:0] sum_x_r, sum_y_r;
  logic out_valid_r;

  logic [DW-1:0] dx_r, dy_r, ax_r, ay_r;
  logic [31:0]   m2_r;
  logic [AW-1:0] a_r;
  logic          skip_r;
  logic [SW-1:0] s_r;
  logic [RW-1:0] r_r;
  logic [PW-1:0] den_r, p_r;
  logic [QW-1:0] qx_r, qy_r;

  logic          busy_r;
  op_t           op_r;
  logic [CNTW-1:0] cnt_r;
  logic [PW-1:0] ma_r, macc_r, macc_nxt;
  logic [RW-1:0] mb_r;
  logic [2*RW-1:0] srad_r;
  logic [RW+2:0] srem_r, srem_sh, strial, srem_nxt;
  logic [RW-1:0] sroot_r, sroot_nxt;
  logic [PW-1:0] drem_r, drem_nxt;
  logic [DDW-1:0] dd_r;
  logic [QW-1:0] dq_r, dq_nxt;
  logic          dge;

  logic [DW-1:0] dx_in, dy_in, ax_in, ay_in;
  logic [AW-1:0] a_in;
  logic          skip_in;
  logic [SW-1:0] l_sh, l_val;
  logic [34:0]   fx, fy;
  logic [32:0]   rx, ry;
  logic          done;

  function automatic logic [34:0] fcomp(input logic [DW-1:0] d, input logic [QW-1:0] q);
    logic pos, big;
    logic [QW-1:0] lim, m;
    logic [33:0] f;
    pos = !d[DW-1] && (d != '0);
    lim = pos ? 33'h080000000 : 33'h07FFFFFFF;
    big = q > lim;
    m   = big ? lim : q;
    f   = pos ? -{1'b0, m} : {1'b0, m};
    if (d == '0) fcomp = '0;
    else fcomp = {big, f};
  endfunction

  function automatic logic [32:0] rclamp(input logic [31:0] s, input logic [33:0] f);
    logic signed [33:0] v;
    v = $signed({{2{s[31]}}, s}) - $signed(f);
    if (v > 34'sh07FFFFFFF) rclamp = {1'b1, 32'h7FFFFFFF};
    else if (v < -34'sh080000000) rclamp = {1'b1, 32'h80000000};
    else rclamp = {1'b0, v[31:0]};
  endfunction

  always_comb begin
    dx_in   = {in_tdata[31], in_tdata[31:0]} - {cx_r[31], cx_r};
    dy_in   = {in_tdata[63], in_tdata[63:32]} - {cy_r[31], cy_r};
    ax_in   = dx_in[DW-1] ? -dx_in : dx_in;
    ay_in   = dy_in[DW-1] ? -dy_in : dy_in;
    a_in    = AW'(mass_r) * AW'(mult_r);
    skip_in = !in_tuser[0] || (a_in[AW-1:16] <= EPS) || (dx_in == '0 && dy_in == '0);
    l_sh    = s_r >> FRAC_BITS;
    l_val   = (l_sh < ONE) ? ONE : l_sh;
    macc_nxt = macc_r + (mb_r[0] ? ma_r : '0);
    // two radicand bits per root bit
    srem_sh  = {srem_r[RW:0], srad_r[2*RW-1 -: 2]};
    strial   = {1'b0, sroot_r, 2'b01};
    srem_nxt = (srem_sh >= strial) ? srem_sh - strial : srem_sh;
    sroot_nxt = {sroot_r[RW-2:0], srem_sh >= strial};
    dge      = {{(DDW-PW){1'b0}}, drem_r} >= dd_r;
    drem_nxt = dge ? drem_r - dd_r[PW-1:0] : drem_r;
    dq_nxt   = {dq_r[QW-2:0], dge};
    done     = busy_r && cnt_r == '0;
    fx = fcomp(dx_r, qx_r);
    fy = fcomp(dy_r, qy_r);
    rx = rclamp(sum_x_r, fx[33:0]);
    ry = rclamp(sum_y_r, fy[33:0]);
  end

  assign st.done     = done;
  assign st.skip     = skip_r;
  assign st.out_free = !out_valid_r || out_tready;
  assign out_tvalid  = out_valid_r;

  // config, reaction totals and output handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r <= '0; cy_r <= '0; mass_r <= 32'd65536; mult_r <= 17'd65536;
      sum_x_r <= '0; sum_y_r <= '0; out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_CENTER_X:   cx_r   <= cfg_wdata;
          CFG_CENTER_Y:   cy_r   <= cfg_wdata;
          CFG_MASS:       mass_r <= cfg_wdata;
          CFG_MULTIPLIER: mult_r <= cfg_wdata[16:0];
          default: ;
        endcase
      end
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      if (cmd.load && in_tuser[1]) begin
        sum_x_r <= '0;
        sum_y_r <= '0;
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
        if (!skip_r) begin
          sum_x_r <= rx[31:0];
          sum_y_r <= ry[31:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) busy_r <= 1'b0;
    else if (cmd.start) busy_r <= 1'b1;
    else if (done) busy_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dx_r <= dx_in; dy_r <= dy_in; ax_r <= ax_in; ay_r <= ay_in;
      m2_r <= in_tdata[95:64]; a_r <= a_in; skip_r <= skip_in;
    end
    if (cmd.start) begin
      op_r   <= cmd.op;
      macc_r <= '0;
      case (cmd.op)
        OP_MUL_XX: begin ma_r <= PW'(ax_r); mb_r <= RW'(ax_r); cnt_r <= CNTW'(RW-1); end
        OP_MUL_YY: begin ma_r <= PW'(ay_r); mb_r <= RW'(ay_r); cnt_r <= CNTW'(RW-1); end
        OP_MUL_LR: begin ma_r <= PW'(l_val); mb_r <= r_r; cnt_r <= CNTW'(RW-1); end
        OP_MUL_AM: begin ma_r <= PW'(a_r); mb_r <= RW'(m2_r); cnt_r <= CNTW'(RW-1); end
        OP_MUL_PX: begin ma_r <= p_r; mb_r <= RW'(ax_r); cnt_r <= CNTW'(RW-1); end
        OP_MUL_PY: begin ma_r <= p_r; mb_r <= RW'(ay_r); cnt_r <= CNTW'(RW-1); end
        OP_SQRT: begin
          srad_r <= (2*RW)'(s_r); srem_r <= '0; sroot_r <= '0; cnt_r <= CNTW'(RW-1);
        end
        OP_DIV_X, OP_DIV_Y: begin
          drem_r <= macc_r; dd_r <= {den_r, {(QW-1){1'b0}}}; dq_r <= '0;
          cnt_r <= CNTW'(QW-1);
        end
        default: cnt_r <= '0;
      endcase
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      case (op_r)
        OP_SQRT: begin
          srad_r <= srad_r << 2; srem_r <= srem_nxt; sroot_r <= sroot_nxt;
          if (done) r_r <= sroot_nxt;
        end
        OP_DIV_X, OP_DIV_Y: begin
          drem_r <= drem_nxt; dd_r <= dd_r >> 1; dq_r <= dq_nxt;
          if (done && op_r == OP_DIV_X) qx_r <= dq_nxt;
          if (done && op_r == OP_DIV_Y) qy_r <= dq_nxt;
        end
        default: begin
          macc_r <= macc_nxt; ma_r <= ma_r << 1; mb_r <= mb_r >> 1;
          if (done) begin
            case (op_r)
              OP_MUL_XX: s_r <= macc_nxt[SW-1:0];
              OP_MUL_YY: s_r <= s_r + macc_nxt[SW-1:0];
              OP_MUL_LR: den_r <= macc_nxt << MUL_FRAC;
              OP_MUL_AM: p_r <= macc_nxt;
              default: ;
            endcase
          end
        end
      endcase
    end
    if (cmd.finish) begin
      if (skip_r) begin
        out_tdata <= {sum_y_r, sum_x_r, 64'd0};
        out_tuser <= 1'b0;
      end else begin
        out_tdata <= {ry[31:0], rx[31:0], fy[31:0], fx[31:0]};
        out_tuser <= fx[34] | fy[34] | rx[32] | ry[32];
      end
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
// self-checking stream testbench for the point mass gravity force block
`timescale 1ns / 1ps

module testbench;
  import pmg_pkg::*;

  typedef struct {
    logic [31:0] force_x;
    logic [31:0] force_y;
    logic [31:0] reaction_x;
    logic [31:0] reaction_y;
    logic        saturated;
  } force_result_t;

  logic         clk;
  logic         rst_n;
  logic         cfg_we;
  logic [2:0]   cfg_index;
  logic [31:0]  cfg_wdata;
  logic         in_tvalid;
  logic         in_tready;
  logic [95:0]  in_tdata;   // body_x, body_y, body_mass
  logic [1:0]   in_tuser;   // eligible, frame_start
  logic         out_tvalid;
  logic         out_tready;
  logic [127:0] out_tdata;  // force_x, force_y, reaction_x, reaction_y
  logic         out_tuser;  // saturated

  // predictor copy of the configuration and the reaction totals
  longint      center_x_q;
  longint      center_y_q;
  logic [31:0] attractor_mass_q;
  logic [16:0] multiplier_q;
  longint      total_x_q;
  longint      total_y_q;

  force_result_t expected_forces[$];
  int          error_count;
  int          idle_cycles;
  bit          steady_send;
  bit          steady_recv;

  localparam int WATCHDOG_LIMIT = 6000;

  point_mass_gravity_force_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // one signed force component, pointing back toward the attractor
  function automatic longint force_component(logic [191:0] quot, longint offset, ref bit sat);
    logic [191:0] lim;
    logic [191:0] mag;
    lim = (offset > 0) ? 192'h8000_0000 : 192'h7FFF_FFFF;
    if (offset == 0) return 0;
    if (quot > lim) begin
      sat = 1'b1;
      mag = lim;
    end else begin
      mag = quot;
    end
    return (offset > 0) ? -longint'(mag[32:0]) : longint'(mag[32:0]);
  endfunction

  function automatic longint add_reaction(longint total, longint frc, ref bit sat);
    longint v;
    v = total - frc;
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      v = 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      v = -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic force_result_t predict_force(logic [31:0] bx, logic [31:0] by,
                                                  logic [31:0] mass, logic elig, logic fs);
    force_result_t res;
    bit           sat;
    longint       dx, dy, fx, fy;
    logic [191:0] strength, ax, ay, sq, root, cand, lsq, den, prod;
    sat = 1'b0;
    fx = 0;
    fy = 0;
    strength = 192'(attractor_mass_q) * 192'(multiplier_q);
    if (fs) begin
      total_x_q = 0;
      total_y_q = 0;
    end
    if (elig && (strength >> MUL_FRAC) > 192'd6) begin
      dx = longint'($signed(bx)) - center_x_q;
      dy = longint'($signed(by)) - center_y_q;
      if (dx != 0 || dy != 0) begin
        ax = 192'(dx < 0 ? -dx : dx);
        ay = 192'(dy < 0 ? -dy : dy);
        sq = ax * ax + ay * ay;
        root = '0;
        for (int b = 34; b >= 0; b--) begin
          cand = root | (192'd1 << b);
          if (cand * cand <= sq) root = cand;
        end
        lsq = sq >> 16;
        if (lsq < 192'd65536) lsq = 192'd65536;
        den = (lsq * root) << MUL_FRAC;
        prod = strength * 192'(mass);
        fx = force_component((prod * ax) / den, dx, sat);
        fy = force_component((prod * ay) / den, dy, sat);
        total_x_q = add_reaction(total_x_q, fx, sat);
        total_y_q = add_reaction(total_y_q, fy, sat);
      end
    end
    res.force_x = fx[31:0];
    res.force_y = fy[31:0];
    res.reaction_x = total_x_q[31:0];
    res.reaction_y = total_y_q[31:0];
    res.saturated = sat;
    return res;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h", field, got, want);
    error_count++;
  endtask

  // output side: random stalls, result checking and the watchdog
  always @(posedge clk) begin
    force_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      idle_cycles <= 0;
    end else begin
      out_tready <= steady_recv || ($urandom_range(99) >= 17);
      if ((out_tvalid && out_tready) || (in_tvalid && in_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
      if (out_tvalid && out_tready) begin
        if (expected_forces.size() == 0) begin
          report_mismatch("unexpected transfer", out_tdata[31:0], 32'd0);
        end else begin
          want = expected_forces.pop_front();
          if (out_tdata[31:0] !== want.force_x)
            report_mismatch("force_x", out_tdata[31:0], want.force_x);
          if (out_tdata[63:32] !== want.force_y)
            report_mismatch("force_y", out_tdata[63:32], want.force_y);
          if (out_tdata[95:64] !== want.reaction_x)
            report_mismatch("reaction_x", out_tdata[95:64], want.reaction_x);
          if (out_tdata[127:96] !== want.reaction_y)
            report_mismatch("reaction_y", out_tdata[127:96], want.reaction_y);
          if (out_tuser !== want.saturated)
            report_mismatch("saturated", 32'(out_tuser), 32'(want.saturated));
        end
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_CENTER_X:   center_x_q = longint'($signed(value));
      CFG_CENTER_Y:   center_y_q = longint'($signed(value));
      CFG_MASS:       attractor_mass_q = value;
      CFG_MULTIPLIER: multiplier_q = value[16:0];
      default: ;
    endcase
  endtask

  task automatic send_body(logic [31:0] bx, logic [31:0] by, logic [31:0] mass,
                           logic elig, logic fs);
    if (!steady_send && $urandom_range(99) < 17) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {mass, by, bx};
    in_tuser <= {fs, elig};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_forces.push_back(predict_force(bx, by, mass, elig, fs));
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_forces.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [31:0] random_word();
    case ($urandom_range(3))
      0: return $urandom();
      1: return $urandom() >> $urandom_range(31);
      2: return -($urandom() >> $urandom_range(31));
      default: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
    endcase
  endfunction

  task automatic test_special_cases();
    send_body(32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 1'b1, 1'b1);
    send_body(32'h0003_0000, 32'hFFFF_0000, 32'h0004_0000, 1'b0, 1'b0);  // not dynamic
    send_body(32'h0000_0000, 32'h0000_0000, 32'h0010_0000, 1'b1, 1'b0);  // coincident
    send_body(32'h0000_0100, 32'h0000_0000, 32'h0001_0000, 1'b1, 1'b0);  // inside unit radius
    send_body(32'h0000_0000, 32'hFFFF_FF00, 32'hFFFF_FFFF, 1'b1, 1'b0);
    send_body(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0);
    send_body(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 1'b1);
    send_body(32'h0000_0001, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0);
    wait_drained();
    // weak attractor, right at and just above the threshold
    write_reg(CFG_MASS, 32'd6);
    send_body(32'h0005_0000, 32'h0005_0000, 32'h0100_0000, 1'b1, 1'b0);
    wait_drained();
    write_reg(CFG_MASS, 32'd7);
    send_body(32'h0005_0000, 32'h0005_0000, 32'h0100_0000, 1'b1, 1'b0);
    wait_drained();
    write_reg(CFG_MULTIPLIER, 32'd0);
    send_body(32'h0005_0000, 32'h0005_0000, 32'h0100_0000, 1'b1, 1'b0);
    wait_drained();
  endtask

  task automatic test_saturation_extremes();
    write_reg(CFG_MASS, 32'hFFFF_FFFF);
    write_reg(CFG_MULTIPLIER, 32'h0001_FFFF);
    write_reg(CFG_CENTER_X, 32'h8000_0000);
    write_reg(CFG_CENTER_Y, 32'h7FFF_FFFF);
    write_reg(3'd5, 32'hDEAD_BEEF);  // unused index, ignored
    // huge forces: minimum force reaction clips
    send_body(32'h8000_0001, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
    send_body(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0);
    send_body(32'h8000_0000, 32'h7FFF_FFFE, 32'hFFFF_FFFF, 1'b1, 1'b0);
    send_body(32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0);
    send_body(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0);
    send_body(32'h0000_0000, 32'h0000_0000, 32'h0000_0001, 1'b1, 1'b0);
    wait_drained();
    write_reg(CFG_MULTIPLIER, 32'd65536);
    write_reg(CFG_CENTER_X, 32'h7FFF_FFFF);
    write_reg(CFG_CENTER_Y, 32'h8000_0000);
    send_body(32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000, 1'b1, 1'b1);
    send_body(32'h7FFF_FFFE, 32'h8000_0001, 32'hFFFF_FFFF, 1'b1, 1'b0);
    wait_drained();
  endtask

  task automatic test_random_gravity(int count);
    logic [31:0] bx, by, mass;
    for (int i = 0; i < count; i++) begin
      if (i % 250 == 0) begin
        wait_drained();
        write_reg(CFG_CENTER_X, random_word());
        write_reg(CFG_CENTER_Y, random_word());
        write_reg(CFG_MASS, random_word());
        write_reg(CFG_MULTIPLIER, $urandom_range(20) == 0 ? $urandom_range(131071)
                                                          : $urandom_range(65536));
      end
      steady_send = (i >= 600 && i < 800);
      steady_recv = (i >= 650 && i < 850);
      if (i == 1000) wait_drained();
      if ($urandom_range(3) == 0) begin
        bx = random_word();
        by = random_word();
      end else begin
        // bodies near the attractor, where forces are moderate
        bx = 32'(center_x_q) + (random_word() >>> $urandom_range(12));
        by = 32'(center_y_q) + (random_word() >>> $urandom_range(12));
      end
      mass = random_word();
      send_body(bx, by, mass, $urandom_range(9) != 0, $urandom_range(15) == 0);
    end
    steady_send = 1'b0;
    steady_recv = 1'b0;
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    error_count = 0;
    idle_cycles = 0;
    steady_send = 1'b0;
    steady_recv = 1'b0;
    center_x_q = 0;
    center_y_q = 0;
    attractor_mass_q = 32'd65536;
    multiplier_q = 17'd65536;
    total_x_q = 0;
    total_y_q = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_special_cases();
    test_saturation_extremes();
    test_random_gravity(1750);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
